// ----- rtl/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, letter codes and square geometry for the Playfair stream core.
// ----------------------------------------------------------------------------
package pfc_pkg;

   localparam int SQUARE_SIDE = 5;
   localparam int NUM_CELLS   = SQUARE_SIDE * SQUARE_SIDE;
   localparam int NUM_LETTERS = 26;

   localparam logic [4:0] LTR_I     = 5'd8;
   localparam logic [4:0] LTR_J     = 5'd9;
   localparam logic [4:0] LTR_X     = 5'd23;
   localparam logic [4:0] LTR_LAST  = 5'd25;
   localparam logic [4:0] NO_LETTER = 5'd26;
   localparam logic [4:0] CELLS_MAX = 5'(NUM_CELLS);
   localparam logic [2:0] SIDE_MAX  = 3'(SQUARE_SIDE - 1);

   localparam logic [7:0] ASCII_A_UP = 8'h41;
   localparam logic [7:0] ASCII_Z_UP = 8'h5a;
   localparam logic [7:0] ASCII_A    = 8'h61;
   localparam logic [7:0] ASCII_Z    = 8'h7a;
   localparam logic [7:0] CASE_GAP   = 8'h20;

   typedef enum logic [1:0] {
      REQ_KEY_BYTE = 2'd0,
      REQ_KEY_DONE = 2'd1,
      REQ_TEXT     = 2'd2,
      REQ_MSG_END  = 2'd3
   } req_code_type;

   // one write into both lookup memories
   typedef struct packed {
      logic       en;
      logic [4:0] cell_no;
      logic [4:0] letter;
   } wr_req_type;

   // row of a cell: cell / 5 as multiply by 13, shift by 6 (exact below 25)
   function automatic logic [2:0] cell_row(input logic [4:0] cell_no);
      logic [8:0] prod;
      prod = 9'(cell_no) * 9'd13;
      return prod[8:6];
   endfunction

   function automatic logic [4:0] times_side(input logic [2:0] v);
      return {v, 2'b00} + {2'b00, v};
   endfunction

   function automatic logic [2:0] cell_col(input logic [4:0] cell_no);
      logic [4:0] base;
      base = times_side(cell_row(cell_no));
      return 3'(cell_no - base);
   endfunction

endpackage

// ----- rtl/pfc_store.sv -----
// ----------------------------------------------------------------------------
// pfc_store
// Square memory (cell -> letter) and its inverse (letter -> cell), each with
// one write port and two registered read ports.
// ----------------------------------------------------------------------------
module pfc_store (
   input  logic               clock,
   input  pfc_pkg::wr_req_type wr,
   input  logic [4:0]         letter_a,
   input  logic [4:0]         letter_b,
   output logic [4:0]         cell_a,
   output logic [4:0]         cell_b,
   input  logic [4:0]         cell_p,
   input  logic [4:0]         cell_q,
   output logic [4:0]         letter_p,
   output logic [4:0]         letter_q
);
   import pfc_pkg::*;

   logic [4:0] square_mem [NUM_CELLS];
   logic [4:0] cell_mem   [NUM_LETTERS];

   logic [4:0] cell_a_ff, cell_b_ff, letter_p_ff, letter_q_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         square_mem[wr.cell_no] <= wr.letter;
         cell_mem[wr.letter]    <= wr.cell_no;
      end
      cell_a_ff   <= cell_mem[letter_a];
      cell_b_ff   <= cell_mem[letter_b];
      letter_p_ff <= square_mem[cell_p];
      letter_q_ff <= square_mem[cell_q];
   end

   assign cell_a   = cell_a_ff;
   assign cell_b   = cell_b_ff;
   assign letter_p = letter_p_ff;
   assign letter_q = letter_q_ff;

endmodule

// ----- rtl/pfc_subst.sv -----
// ----------------------------------------------------------------------------
// pfc_subst
// Pair substitution: row, column and rectangle rules on two square cells.
// ----------------------------------------------------------------------------
module pfc_subst (
   input  logic       decrypt,
   input  logic [4:0] cell_a,
   input  logic [4:0] cell_b,
   output logic [4:0] cell_p,
   output logic [4:0] cell_q
);
   import pfc_pkg::*;

   function automatic logic [2:0] shift_pos(input logic [2:0] v, input logic dec);
      logic [2:0] r;
      if (dec) r = (v == 3'd0) ? SIDE_MAX : v - 3'd1;
      else     r = (v == SIDE_MAX) ? 3'd0 : v + 3'd1;
      return r;
   endfunction

   logic [2:0] ya, xa, yb, xb;

   always_comb begin
      ya = cell_row(cell_a);
      xa = cell_col(cell_a);
      yb = cell_row(cell_b);
      xb = cell_col(cell_b);
      if (ya == yb) begin
         cell_p = times_side(ya) + 5'(shift_pos(xa, decrypt));
         cell_q = times_side(yb) + 5'(shift_pos(xb, decrypt));
      end else if (xa == xb) begin
         cell_p = times_side(shift_pos(ya, decrypt)) + 5'(xa);
         cell_q = times_side(shift_pos(yb, decrypt)) + 5'(xb);
      end else begin
         cell_p = times_side(ya) + 5'(xb);
         cell_q = times_side(yb) + 5'(xa);
      end
   end

endmodule

// ----- rtl/playfair_cipher_stream_core.sv -----
// ----------------------------------------------------------------------------
// playfair_cipher_stream_core
// Playfair cipher over a byte stream: builds the 5x5 square from key bytes,
// then encrypts or decrypts text letters pair by pair.
//
//   channel | ports                                   | direction
//   req     | req_valid/req_ready, req_type, data     | in
//   rsp     | rsp_valid/rsp_ready, letter, end, last  | out
//   csr     | csr_wr_en, csr_wr_data (cipher mode)    | in
//
// Key bytes and unpaired text letters are taken in idle. Key done walks the
// alphabet, one alphabet letter per cycle through the square write port. A
// letter pair passes the cell lookup, substitution, square read and result
// build, then one cycle per result as the rsp side accepts, then idle. A
// message end without a pad pair emits only its end marker. Results go out
// through one output register; a stalled rsp side holds the sequencer.
// Synchronous reset clears the square fill state and returns to key entry.
// ----------------------------------------------------------------------------
module playfair_cipher_stream_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_letter,
   output logic       rsp_end_marker,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import pfc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FILL, ST_LOOK, ST_SUBST, ST_FETCH, ST_BUILD, ST_EMIT
   } state_type;

   state_type  state_ff;
   logic       cipher_mode_ff;
   logic       phase_ff;
   logic [25:0] used_ff;
   logic [4:0] fill_count_ff;
   logic [4:0] fill_idx_ff;
   logic [4:0] held_ff;
   logic       held_valid_ff;
   logic       queued_x_ff;
   logic [4:0] prev_ff;
   logic       dec_ff;
   logic [4:0] op_a_ff, op_b_ff;
   logic [4:0] p_ff, q_ff;
   logic [4:0] lst_ff [4];
   logic [2:0] n_ff, idx_ff;
   logic       end_pend_ff;
   logic       rsp_valid_ff, rsp_end_ff, rsp_last_ff;
   logic [7:0] rsp_letter_ff;

   logic       accept, slot_free, rsp_load;
   logic [7:0] lower;
   logic [4:0] req_letter, text_letter;
   logic       key_place, fill_place;
   wr_req_type wr;
   logic [4:0] cell_a, cell_b, sub_p, sub_q, r1, r2;

   logic [4:0] bld_lst [4];
   logic [2:0] bld_n;
   logic [4:0] prev1, prev2;
   logic       qc1, qc2, emit_x1, emit_r1, emit_x2, emit_r2;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == ST_EMIT) && slot_free &&
                      !(idx_ff == n_ff && !end_pend_ff);

   // fold to lower case, map to a letter index, and j to i for text
   always_comb begin
      lower = req_data_byte;
      if (req_data_byte >= ASCII_A_UP && req_data_byte <= ASCII_Z_UP)
         lower = req_data_byte + CASE_GAP;
      if (lower >= ASCII_A && lower <= ASCII_Z) req_letter = 5'(lower - ASCII_A);
      else                                      req_letter = NO_LETTER;
      text_letter = (req_letter == LTR_J) ? LTR_I : req_letter;
   end

   always_comb begin
      key_place  = accept && (req_type == REQ_KEY_BYTE) && !phase_ff &&
                   (req_letter != NO_LETTER) && (req_letter != LTR_J) &&
                   (fill_count_ff < CELLS_MAX) && !used_ff[req_letter];
      fill_place = (state_ff == ST_FILL) && (fill_idx_ff != LTR_J) &&
                   (fill_count_ff < CELLS_MAX) && !used_ff[fill_idx_ff];
      wr.en      = key_place || fill_place;
      wr.cell_no = fill_count_ff;
      wr.letter  = (state_ff == ST_FILL) ? fill_idx_ff : req_letter;
   end

   pfc_store u_store (
      .clock    (clock),
      .wr       (wr),
      .letter_a (op_a_ff),
      .letter_b (op_b_ff),
      .cell_a   (cell_a),
      .cell_b   (cell_b),
      .cell_p   (p_ff),
      .cell_q   (q_ff),
      .letter_p (r1),
      .letter_q (r2)
   );

   pfc_subst u_subst (
      .decrypt (dec_ff),
      .cell_a  (cell_a),
      .cell_b  (cell_b),
      .cell_p  (sub_p),
      .cell_q  (sub_q)
   );

   // result list of one pair; decrypt holds back an x until its successor
   always_comb begin
      emit_x1 = queued_x_ff && !(prev_ff != NO_LETTER && prev_ff == r1);
      prev1   = queued_x_ff ? LTR_X : prev_ff;
      emit_r1 = (r1 != LTR_X);
      qc1     = !emit_r1;
      if (emit_r1) prev1 = r1;
      emit_x2 = qc1 && !(prev1 != NO_LETTER && prev1 == r2);
      prev2   = qc1 ? LTR_X : prev1;
      emit_r2 = (r2 != LTR_X);
      qc2     = !emit_r2;
      if (emit_r2) prev2 = r2;

      for (int k = 0; k < 4; k++) bld_lst[k] = LTR_X;
      bld_n = 3'd0;
      if (!dec_ff) begin
         bld_lst[0] = r1;
         bld_lst[1] = r2;
         bld_n      = 3'd2;
      end else begin
         if (emit_x1) begin bld_lst[bld_n[1:0]] = LTR_X; bld_n = bld_n + 3'd1; end
         if (emit_r1) begin bld_lst[bld_n[1:0]] = r1;    bld_n = bld_n + 3'd1; end
         if (emit_x2) begin bld_lst[bld_n[1:0]] = LTR_X; bld_n = bld_n + 3'd1; end
         if (emit_r2) begin bld_lst[bld_n[1:0]] = r2;    bld_n = bld_n + 3'd1; end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cipher_mode_ff <= 1'b0;
         phase_ff       <= 1'b0;
         used_ff        <= '0;
         fill_count_ff  <= '0;
         fill_idx_ff    <= '0;
         held_ff        <= '0;
         held_valid_ff  <= 1'b0;
         queued_x_ff    <= 1'b0;
         prev_ff        <= NO_LETTER;
         end_pend_ff    <= 1'b0;
         n_ff           <= '0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_wr_en) cipher_mode_ff <= csr_wr_data;
         if (wr.en) begin
            used_ff[wr.letter] <= 1'b1;
            fill_count_ff      <= fill_count_ff + 5'd1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_type)
                     REQ_KEY_DONE: begin
                        if (!phase_ff) begin
                           fill_idx_ff <= '0;
                           state_ff    <= ST_FILL;
                        end
                     end
                     REQ_TEXT: begin
                        if (phase_ff && req_letter != NO_LETTER) begin
                           if (!held_valid_ff) begin
                              held_ff       <= text_letter;
                              held_valid_ff <= 1'b1;
                           end else begin
                              op_a_ff     <= held_ff;
                              dec_ff      <= cipher_mode_ff;
                              end_pend_ff <= 1'b0;
                              state_ff    <= ST_LOOK;
                              if (!cipher_mode_ff && held_ff == text_letter) begin
                                 op_b_ff <= LTR_X;
                              end else begin
                                 op_b_ff       <= text_letter;
                                 held_valid_ff <= 1'b0;
                              end
                           end
                        end
                     end
                     REQ_MSG_END: begin
                        held_valid_ff <= 1'b0;
                        held_ff       <= '0;
                        queued_x_ff   <= 1'b0;
                        prev_ff       <= NO_LETTER;
                        end_pend_ff   <= 1'b1;
                        idx_ff        <= '0;
                        if (phase_ff && held_valid_ff && !cipher_mode_ff) begin
                           op_a_ff  <= held_ff;
                           op_b_ff  <= LTR_X;
                           dec_ff   <= 1'b0;
                           state_ff <= ST_LOOK;
                        end else begin
                           n_ff     <= '0;
                           state_ff <= ST_EMIT;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_FILL: begin
               if (fill_idx_ff == LTR_LAST) begin
                  phase_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  fill_idx_ff <= fill_idx_ff + 5'd1;
               end
            end
            ST_LOOK:  state_ff <= ST_SUBST;
            ST_SUBST: begin
               p_ff     <= sub_p;
               q_ff     <= sub_q;
               state_ff <= ST_FETCH;
            end
            ST_FETCH: state_ff <= ST_BUILD;
            ST_BUILD: begin
               for (int k = 0; k < 4; k++) lst_ff[k] <= bld_lst[k];
               n_ff   <= bld_n;
               idx_ff <= '0;
               if (dec_ff) begin
                  prev_ff     <= prev2;
                  queued_x_ff <= qc2;
               end
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (idx_ff == n_ff && !end_pend_ff) begin
                  state_ff <= ST_IDLE;
               end else if (slot_free) begin
                  if (idx_ff != n_ff) begin
                     rsp_letter_ff <= ASCII_A + 8'(lst_ff[idx_ff[1:0]]);
                     rsp_end_ff    <= 1'b0;
                     rsp_last_ff   <= (idx_ff + 3'd1 == n_ff) && !end_pend_ff;
                     idx_ff        <= idx_ff + 3'd1;
                  end else begin
                     rsp_letter_ff <= '0;
                     rsp_end_ff    <= 1'b1;
                     rsp_last_ff   <= 1'b1;
                     end_pend_ff   <= 1'b0;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_letter = rsp_letter_ff;
   assign rsp_end_marker = rsp_end_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ----- rtl/pfc_checker.sv -----
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level checks for the Playfair stream core, bound to the top level.
// ----------------------------------------------------------------------------
module pfc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_type,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_letter,
   input logic       rsp_end_marker,
   input logic       rsp_last
);
   import pfc_pkg::*;

   // end marker item carries no letter and closes the item's results
   a_end_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_marker |-> rsp_out_letter == 8'h00 && rsp_last)
      else $error("end marker item with letter or without last");

   // every other result is a lower-case letter
   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_marker |-> rsp_out_letter >= ASCII_A && rsp_out_letter <= ASCII_Z)
      else $error("result letter out of range");

   // a message end always produces its marker, so intake stops for it
   a_msg_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_MSG_END |=> !req_ready)
      else $error("ready right after message end");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_letter) &&
         $stable(rsp_end_marker) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind playfair_cipher_stream_core pfc_checker u_pfc_checker (.*);

// ----- bench/playfair_cipher_stream_core_tb.sv -----
// ----------------------------------------------------------------------------
// playfair_cipher_stream_core_tb
// Builds one key square, then runs messages through the core in both cipher
// modes with bursty input and a stalling receiver. Every result item is checked
// against an in-bench behavioral Playfair predictor or a typed row's exp_end.
// ----------------------------------------------------------------------------
module playfair_cipher_stream_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pfc_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE      = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int DIR_ROWS    = 24;
   localparam int ITEM_TARGET = 110;
   localparam logic [5:0] PREV_NONE = 6'd26;

   typedef struct packed {
      logic [7:0] letter;
      logic       endm;
      logic       last;
   } rsp_item_type;

   typedef struct {
      req_code_type typ;
      logic [7:0]   data;
      bit           typed;
      bit           exp_end;
   } dir_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_type = REQ_KEY_BYTE;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_letter;
   logic       rsp_end_marker;
   logic       rsp_last;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   // predictor state
   logic [4:0]  sq_letter [NUM_CELLS];
   logic [4:0]  ltr_cell [NUM_LETTERS];
   logic [25:0] ltr_used;
   int          fill_n;
   bit          text_phase;
   logic [4:0]  held_ltr;
   bit          held_v;
   bit          x_wait;
   logic [5:0]  prev_ltr;
   bit          dec_mode;

   rsp_item_type step_letters [$];
   rsp_item_type letters_due [$];
   logic [7:0]   cipher_log [$];

   int          err_cnt = 0;
   int          cycle_cnt = 0;
   int          item_cnt = 0;
   int          burst_left = 0;
   bit          gaps_on = 1'b1;
   int          hold_off_reqs = 0;
   logic [4:0]  plain_prev = 5'd0;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{REQ_MSG_END,  8'h00, 1'b1, 1'b1},   // end marker alone during key entry
      '{REQ_TEXT,     "a",   1'b1, 1'b0},   // text before the square exists
      '{REQ_KEY_BYTE, 8'h00, 1'b1, 1'b0},
      '{REQ_KEY_BYTE, "P",   1'b1, 1'b0},
      '{REQ_KEY_BYTE, "l",   1'b1, 1'b0},
      '{REQ_KEY_BYTE, "a",   1'b1, 1'b0},
      '{REQ_KEY_BYTE, "j",   1'b1, 1'b0},
      '{REQ_KEY_BYTE, "A",   1'b1, 1'b0},
      '{REQ_KEY_BYTE, "Z",   1'b1, 1'b0},
      '{REQ_KEY_BYTE, 8'hff, 1'b1, 1'b0},
      '{REQ_KEY_DONE, 8'h00, 1'b1, 1'b0},
      '{REQ_KEY_DONE, 8'hff, 1'b1, 1'b0},   // square already full
      '{REQ_KEY_BYTE, "q",   1'b1, 1'b0},   // key byte during text
      '{REQ_TEXT,     "h",   1'b0, 1'b0},
      '{REQ_TEXT,     "E",   1'b0, 1'b0},
      '{REQ_TEXT,     "l",   1'b0, 1'b0},
      '{REQ_TEXT,     "l",   1'b0, 1'b0},
      '{REQ_TEXT,     "x",   1'b0, 1'b0},
      '{REQ_TEXT,     "x",   1'b0, 1'b0},
      '{REQ_TEXT,     "x",   1'b0, 1'b0},
      '{REQ_TEXT,     "J",   1'b0, 1'b0},
      '{REQ_TEXT,     "q",   1'b0, 1'b0},
      '{REQ_TEXT,     "!",   1'b1, 1'b0},
      '{REQ_MSG_END,  8'h00, 1'b0, 1'b0}
   };

   playfair_cipher_stream_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_letter (rsp_out_letter),
      .rsp_end_marker (rsp_end_marker),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Playfair predictor
   // ------------------------------------------------------------------
   function automatic void emit_letter(input logic [4:0] ltr, input bit endm);
      rsp_item_type r;
      r.letter = endm ? 8'h00 : ASCII_A + 8'(ltr);
      r.endm   = endm;
      r.last   = 1'b0;
      step_letters.push_back(r);
   endfunction

   function automatic void place_letter(input logic [4:0] ltr);
      if (fill_n < NUM_CELLS) begin
         sq_letter[fill_n] = ltr;
         ltr_cell[ltr]     = 5'(fill_n);
         ltr_used[ltr]     = 1'b1;
         fill_n++;
      end
   endfunction

   function automatic void substitute_pair(input logic [4:0] a, input logic [4:0] b,
                                           input bit dec,
                                           output logic [4:0] r1, output logic [4:0] r2);
      int ya, xa, yb, xb, d, p, q;
      ya = int'(ltr_cell[a]) / SQUARE_SIDE;
      xa = int'(ltr_cell[a]) % SQUARE_SIDE;
      yb = int'(ltr_cell[b]) / SQUARE_SIDE;
      xb = int'(ltr_cell[b]) % SQUARE_SIDE;
      d  = dec ? SQUARE_SIDE - 1 : 1;
      if (ya == yb) begin
         p = ya * SQUARE_SIDE + (xa + d) % SQUARE_SIDE;
         q = yb * SQUARE_SIDE + (xb + d) % SQUARE_SIDE;
      end else if (xa == xb) begin
         p = ((ya + d) % SQUARE_SIDE) * SQUARE_SIDE + xa;
         q = ((yb + d) % SQUARE_SIDE) * SQUARE_SIDE + xb;
      end else begin
         p = ya * SQUARE_SIDE + xb;
         q = yb * SQUARE_SIDE + xa;
      end
      r1 = sq_letter[p];
      r2 = sq_letter[q];
      if (!dec) begin
         emit_letter(r1, 1'b0);
         emit_letter(r2, 1'b0);
      end
   endfunction

   // decrypt side: hold a decoded x until its successor shows whether it was filler
   function automatic void push_plain(input logic [4:0] d);
      if (x_wait) begin
         if (!(prev_ltr != PREV_NONE && prev_ltr == {1'b0, d}))
            emit_letter(LTR_X, 1'b0);
         prev_ltr = {1'b0, LTR_X};
         x_wait   = 1'b0;
      end
      if (d == LTR_X) begin
         x_wait = 1'b1;
      end else begin
         emit_letter(d, 1'b0);
         prev_ltr = {1'b0, d};
      end
   endfunction

   function automatic void clear_playfair();
      foreach (sq_letter[i]) sq_letter[i] = 5'd0;
      foreach (ltr_cell[i]) ltr_cell[i] = 5'd0;
      ltr_used   = '0;
      fill_n     = 0;
      text_phase = 1'b0;
      held_ltr   = 5'd0;
      held_v     = 1'b0;
      x_wait     = 1'b0;
      prev_ltr   = PREV_NONE;
      dec_mode   = 1'b0;
   endfunction

   // advance the predictor by one input item
   function automatic void playfair_step(input req_code_type typ, input logic [7:0] raw);
      logic [7:0] c;
      logic [4:0] ltr, r1, r2;
      c = raw;
      step_letters.delete();
      if (c >= ASCII_A_UP && c <= ASCII_Z_UP) c = c + CASE_GAP;
      ltr = (c >= ASCII_A && c <= ASCII_Z) ? 5'(c - ASCII_A) : NO_LETTER;
      case (typ)
         REQ_KEY_BYTE: begin
            if (!text_phase) begin
               if (ltr != NO_LETTER && ltr != LTR_J && !ltr_used[ltr]) place_letter(ltr);
            end
         end
         REQ_KEY_DONE: begin
            if (!text_phase) begin
               for (int i = 0; i < NUM_LETTERS; i++)
                  if (5'(i) != LTR_J && !ltr_used[i]) place_letter(5'(i));
               text_phase = 1'b1;
            end
         end
         REQ_TEXT: begin
            if (text_phase && ltr != NO_LETTER) begin
               if (ltr == LTR_J) ltr = LTR_I;
               if (!held_v) begin
                  held_ltr = ltr;
                  held_v   = 1'b1;
               end else if (!dec_mode) begin
                  // equal pair: insert x, keep the letter held for the next pair
                  if (held_ltr == ltr) begin
                     substitute_pair(held_ltr, LTR_X, 1'b0, r1, r2);
                  end else begin
                     substitute_pair(held_ltr, ltr, 1'b0, r1, r2);
                     held_v = 1'b0;
                  end
               end else begin
                  substitute_pair(held_ltr, ltr, 1'b1, r1, r2);
                  held_v = 1'b0;
                  push_plain(r1);
                  push_plain(r2);
               end
            end
         end
         default: begin
            if (text_phase && held_v && !dec_mode)
               substitute_pair(held_ltr, LTR_X, 1'b0, r1, r2);
            held_v   = 1'b0;
            held_ltr = 5'd0;
            x_wait   = 1'b0;
            prev_ltr = PREV_NONE;
            emit_letter(5'd0, 1'b1);
         end
      endcase
      if (step_letters.size() > 0) step_letters[step_letters.size() - 1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("ERROR: %s (cycle %0d)", msg, cycle_cnt);
      err_cnt++;
   endtask

   task automatic send_item(input req_code_type typ, input logic [7:0] data,
                            input bit typed, input bit exp_end);
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_valid     <= 1'b1;
      req_type      <= typ;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      playfair_step(typ, data);
      if (typed) begin
         step_letters.delete();
         if (exp_end) step_letters.push_back('{8'h00, 1'b1, 1'b1});
      end
      foreach (step_letters[i]) begin
         letters_due.push_back(step_letters[i]);
         if (!dec_mode && !step_letters[i].endm) cipher_log.push_back(step_letters[i].letter);
      end
      item_cnt++;
   endtask

   // drop valid, wait out every expected result, then let the core settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (letters_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_mode(input bit m);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      dec_mode = m;
   endtask

   // plaintext biased toward doubled letters, x and j
   function automatic logic [7:0] plain_byte();
      logic [4:0] l;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) l = plain_prev;
      else if (pick < 40) l = LTR_X;
      else if (pick < 48) l = LTR_J;
      else l = 5'($urandom_range(0, LTR_LAST));
      plain_prev = l;
      return ($urandom_range(0, 1) ? ASCII_A_UP : ASCII_A) + 8'(l);
   endfunction

   task automatic send_noise();
      send_item(req_code_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, 1'b0);
   endtask

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------
   task automatic check_letter();
      rsp_item_type want;
      if (letters_due.size() == 0) begin
         report_mismatch($sformatf("unexpected item letter=%02h end=%0b last=%0b",
                                   rsp_out_letter, rsp_end_marker, rsp_last));
      end else begin
         want = letters_due.pop_front();
         if (rsp_out_letter !== want.letter)
            report_mismatch($sformatf("letter %02h, want %02h", rsp_out_letter, want.letter));
         if (rsp_end_marker !== want.endm)
            report_mismatch($sformatf("end_marker %0b, want %0b", rsp_end_marker, want.endm));
         if (rsp_last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", rsp_last, want.last));
      end
   endtask

   initial begin : rsp_side
      logic [7:0] pat;
      int         pos;
      int         hold_left;
      int         holds_seen;
      pat        = 8'hff;
      pos        = 0;
      hold_left  = 0;
      holds_seen = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready) check_letter();
         if (hold_off_reqs != holds_seen) begin
            holds_seen = hold_off_reqs;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (pos == 0) pat = ($urandom_range(0, 3) == 0) ? 8'hff :
                                (8'($urandom_range(0, 255)) | 8'h01);
            rsp_ready <= pat[pos % 8];
            pos = (pos + 1) % 64;
         end
      end
   end

   initial begin : watchdog
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int kind;
      int n;
      clear_playfair();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_item(dir_rows[i].typ, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].exp_end);

      for (int round = 0; item_cnt < ITEM_TARGET || round < 5; round++) begin
         kind = round % 4;
         set_mode(kind == 1 ? 1'b1 : (kind == 2 ? 1'($urandom_range(0, 1)) : 1'b0));
         gaps_on = (kind != 3);
         if (kind == 0 || kind == 3) cipher_log.delete();
         // one long receiver hold-off while the sender keeps offering
         if (round == 4) hold_off_reqs++;
         if (kind == 1) begin
            // decode what the last encrypt round produced
            foreach (cipher_log[i]) begin
               if ($urandom_range(0, 9) == 0) send_noise();
               send_item(REQ_TEXT, $urandom_range(0, 1) ? cipher_log[i] - CASE_GAP :
                         cipher_log[i], 1'b0, 1'b0);
            end
         end else begin
            n = (round == 4) ? 24 : $urandom_range(4, 12);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 99) < (kind == 2 ? 50 : 12)) send_noise();
               else send_item(REQ_TEXT, plain_byte(), 1'b0, 1'b0);
            end
         end
         // leave some messages open across a mode change
         if ($urandom_range(0, 9) < 7) send_item(REQ_MSG_END, 8'($urandom_range(0, 255)),
                                                 1'b0, 1'b0);
      end

      wait_idle();
      if (err_cnt == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/pfc_pkg.sv
rtl/pfc_store.sv
rtl/pfc_subst.sv
rtl/playfair_cipher_stream_core.sv
rtl/pfc_checker.sv
bench/playfair_cipher_stream_core_tb.sv
